// ===== sv/bfd_pkg.sv =====
package bfd_pkg;

	// Limits of the block.
	localparam int MAX_RATE   = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths.
	localparam int CH_W   = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DIM_W  = 11;
	localparam int FAC_W  = 4;
	localparam int SUB_W  = $clog2(MAX_RATE);
	localparam int SUM_W  = 14;
	localparam int NCH    = 3;

	// Reciprocal multiply for the divide by the block area.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// Queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// One classified pixel, handed from the front to the back.
	typedef struct packed {
		logic                   first;
		logic                   last;
		logic                   frame_done;
		logic [COL_W-1:0]       x;
		logic [ROW_W-1:0]       y;
		logic [FAC_W-1:0]       factor;
		logic [NCH-1:0][CH_W-1:0] px;
	} rec_t;

	// ceil(2^20 / (f*f)); exact floor quotient for every 14-bit block sum.
	function automatic logic [RECIP_W-1:0] recip(input logic [FAC_W-1:0] f);
		logic [RECIP_W-1:0] m;
		case (f)
			4'd1:    m = RECIP_W'(1048576);
			4'd2:    m = RECIP_W'(262144);
			4'd3:    m = RECIP_W'(116509);
			4'd4:    m = RECIP_W'(65536);
			4'd5:    m = RECIP_W'(41944);
			4'd6:    m = RECIP_W'(29128);
			4'd7:    m = RECIP_W'(21400);
			4'd8:    m = RECIP_W'(16384);
			default: m = RECIP_W'(1048576);
		endcase
		return m;
	endfunction

endpackage

// ===== sv/bfd_pix_if.sv =====
interface bfd_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bfd_pkg::CH_W-1:0]  in_red;
	logic [bfd_pkg::CH_W-1:0]  in_green;
	logic [bfd_pkg::CH_W-1:0]  in_blue;

	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

// ===== sv/bfd_res_if.sv =====
interface bfd_res_if;
	logic                       valid;
	logic                       ready;
	logic [bfd_pkg::CH_W-1:0]   out_red;
	logic [bfd_pkg::CH_W-1:0]   out_green;
	logic [bfd_pkg::CH_W-1:0]   out_blue;
	logic [bfd_pkg::COL_W-1:0]  out_x;
	logic [bfd_pkg::ROW_W-1:0]  out_y;
	logic                       frame_done;

	modport source (output valid, out_red, out_green, out_blue, out_x, out_y, frame_done,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_x, out_y, frame_done,
		output ready);
endinterface

// ===== sv/bfd_cfg_if.sv =====
interface bfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bfd_pkg::CFG_IDX_W-1:0]   index;
	logic [bfd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bfd_front.sv =====
module bfd_front (
	input  logic          clk,
	input  logic          arst_n,
	bfd_pix_if.sink       pix,
	bfd_cfg_if.sink       cfg,
	input  logic          q_full,
	output logic          push,
	output bfd_pkg::rec_t rec
);

	logic [bfd_pkg::FAC_W-1:0] scale_q;
	logic [bfd_pkg::DIM_W-1:0] width_q;
	logic [bfd_pkg::DIM_W-1:0] height_q;

	logic [bfd_pkg::COL_W-1:0] src_col_q;
	logic [bfd_pkg::ROW_W-1:0] src_row_q;
	logic [bfd_pkg::SUB_W-1:0] sub_col_q;
	logic [bfd_pkg::SUB_W-1:0] sub_row_q;
	logic [bfd_pkg::COL_W-1:0] out_col_q;
	logic [bfd_pkg::ROW_W-1:0] out_row_q;
	logic [bfd_pkg::COL_W-1:0] blk_col_q;
	logic [bfd_pkg::ROW_W-1:0] blk_row_q;

	logic [bfd_pkg::FAC_W-1:0] f_c;
	logic [bfd_pkg::DIM_W-1:0] w_c;
	logic [bfd_pkg::DIM_W-1:0] h_c;
	logic [bfd_pkg::DIM_W-1:0] col_end;
	logic [bfd_pkg::DIM_W-1:0] row_end;
	logic [bfd_pkg::DIM_W:0]   col_next_end;
	logic [bfd_pkg::DIM_W:0]   row_next_end;
	logic                      in_col;
	logic                      in_row;
	logic                      last_col;
	logic                      last_row;
	logic                      col_wrap;
	logic                      row_wrap;
	logic                      sub_col_wrap;
	logic                      sub_row_wrap;
	logic                      pix_fire;
	logic                      cfg_hit;

	// Clamp the registers to their legal ranges.
	always_comb begin
		if (scale_q == '0) begin
			f_c = bfd_pkg::FAC_W'(1);
		end else if (scale_q > bfd_pkg::FAC_W'(bfd_pkg::MAX_RATE)) begin
			f_c = bfd_pkg::FAC_W'(bfd_pkg::MAX_RATE);
		end else begin
			f_c = scale_q;
		end
		if (width_q == '0) begin
			w_c = bfd_pkg::DIM_W'(1);
		end else if (width_q > bfd_pkg::DIM_W'(bfd_pkg::MAX_WIDTH)) begin
			w_c = bfd_pkg::DIM_W'(bfd_pkg::MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == '0) begin
			h_c = bfd_pkg::DIM_W'(1);
		end else if (height_q > bfd_pkg::DIM_W'(bfd_pkg::MAX_HEIGHT)) begin
			h_c = bfd_pkg::DIM_W'(bfd_pkg::MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
	end

	// A pixel counts when its whole block fits inside the frame. The block
	// is the last one of its row or column when the next one does not fit.
	always_comb begin
		col_end      = bfd_pkg::DIM_W'(blk_col_q) + bfd_pkg::DIM_W'(f_c);
		row_end      = bfd_pkg::DIM_W'(blk_row_q) + bfd_pkg::DIM_W'(f_c);
		col_next_end = (bfd_pkg::DIM_W+1)'(col_end) + (bfd_pkg::DIM_W+1)'(f_c);
		row_next_end = (bfd_pkg::DIM_W+1)'(row_end) + (bfd_pkg::DIM_W+1)'(f_c);
		in_col       = col_end <= w_c;
		in_row       = row_end <= h_c;
		last_col     = col_next_end > (bfd_pkg::DIM_W+1)'(w_c);
		last_row     = row_next_end > (bfd_pkg::DIM_W+1)'(h_c);
		col_wrap     = (bfd_pkg::DIM_W'(src_col_q) + bfd_pkg::DIM_W'(1)) >= w_c;
		row_wrap     = (bfd_pkg::DIM_W'(src_row_q) + bfd_pkg::DIM_W'(1)) >= h_c;
		sub_col_wrap = (bfd_pkg::FAC_W'(sub_col_q) + bfd_pkg::FAC_W'(1)) >= f_c;
		sub_row_wrap = (bfd_pkg::FAC_W'(sub_row_q) + bfd_pkg::FAC_W'(1)) >= f_c;
	end

	// Handshake and the word pushed into the queue.
	assign pix.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign pix_fire  = pix.valid && pix.ready;
	assign cfg_hit   = cfg.valid && (cfg.index == bfd_pkg::REG_SCALE
		|| cfg.index == bfd_pkg::REG_WIDTH || cfg.index == bfd_pkg::REG_HEIGHT);
	assign push      = pix_fire && in_col && in_row;

	always_comb begin
		rec.first      = (sub_col_q == '0) && (sub_row_q == '0);
		rec.last       = sub_col_wrap && sub_row_wrap;
		rec.frame_done = last_col && last_row;
		rec.x          = out_col_q;
		rec.y          = out_row_q;
		rec.factor     = f_c;
		rec.px         = {pix.in_red, pix.in_green, pix.in_blue};
	end

	// Registers and raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= bfd_pkg::FAC_W'(1);
			width_q   <= bfd_pkg::DIM_W'(1024);
			height_q  <= bfd_pkg::DIM_W'(1024);
			src_col_q <= '0;
			src_row_q <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			blk_col_q <= '0;
			blk_row_q <= '0;
		end else if (cfg_hit) begin
			case (cfg.index)
				bfd_pkg::REG_SCALE:  scale_q  <= cfg.data[bfd_pkg::FAC_W-1:0];
				bfd_pkg::REG_WIDTH:  width_q  <= cfg.data;
				bfd_pkg::REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
			// Any register write restarts the frame.
			src_col_q <= '0;
			src_row_q <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			blk_col_q <= '0;
			blk_row_q <= '0;
		end else if (pix_fire) begin
			if (col_wrap) begin
				src_col_q <= '0;
				sub_col_q <= '0;
				out_col_q <= '0;
				blk_col_q <= '0;
				if (row_wrap) begin
					src_row_q <= '0;
					sub_row_q <= '0;
					out_row_q <= '0;
					blk_row_q <= '0;
				end else begin
					src_row_q <= src_row_q + bfd_pkg::ROW_W'(1);
					if (sub_row_wrap) begin
						sub_row_q <= '0;
						out_row_q <= out_row_q + bfd_pkg::ROW_W'(1);
						blk_row_q <= src_row_q + bfd_pkg::ROW_W'(1);
					end else begin
						sub_row_q <= sub_row_q + bfd_pkg::SUB_W'(1);
					end
				end
			end else begin
				src_col_q <= src_col_q + bfd_pkg::COL_W'(1);
				if (sub_col_wrap) begin
					sub_col_q <= '0;
					out_col_q <= out_col_q + bfd_pkg::COL_W'(1);
					blk_col_q <= src_col_q + bfd_pkg::COL_W'(1);
				end else begin
					sub_col_q <= sub_col_q + bfd_pkg::SUB_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/bfd_queue.sv =====
module bfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bfd_pkg::rec_t wr_rec,
	output logic          full,
	output logic          q_valid,
	input  logic          pop,
	output bfd_pkg::rec_t rd_rec
);

	bfd_pkg::rec_t             q_mem [bfd_pkg::Q_DEPTH];
	logic [bfd_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [bfd_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [bfd_pkg::Q_AW:0]    count_q;

	assign full    = count_q == (bfd_pkg::Q_AW+1)'(bfd_pkg::Q_DEPTH);
	assign q_valid = count_q != '0;
	assign rd_rec  = q_mem[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bfd_pkg::Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bfd_pkg::Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (bfd_pkg::Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (bfd_pkg::Q_AW+1)'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

// ===== sv/bfd_back.sv =====
module bfd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  bfd_pkg::rec_t q_rec,
	output logic          pop,
	bfd_res_if.source     res
);

	typedef logic [bfd_pkg::NCH-1:0][bfd_pkg::SUM_W-1:0] sums_t;

	sums_t                      col_sum_mem [bfd_pkg::MAX_WIDTH];

	// Stage 1: read-modify-write of the column sums.
	logic                       s1_valid_q;
	bfd_pkg::rec_t              rec_s1;
	sums_t                      rdata_s1;
	logic                       fwd_hit_s1;
	sums_t                      fwd_sum_s1;

	// Stage 2: updated column sum; on a block's last pixel, the finished block sum, waiting for the divide.
	logic                       s2_valid_q;
	logic                       last_s2;
	logic                       done_s2;
	logic [bfd_pkg::COL_W-1:0]  x_s2;
	logic [bfd_pkg::ROW_W-1:0]  y_s2;
	logic [bfd_pkg::FAC_W-1:0]  factor_s2;
	sums_t                      sum_s2;

	// Output register.
	logic                       out_valid_q;
	logic [bfd_pkg::NCH-1:0][bfd_pkg::CH_W-1:0] out_px_q;
	logic [bfd_pkg::COL_W-1:0]  out_x_q;
	logic [bfd_pkg::ROW_W-1:0]  out_y_q;
	logic                       out_done_q;

	logic                       out_free;
	logic                       s2_adv;
	logic                       s2_free;
	logic                       s1_adv;
	logic                       s1_free;
	logic                       out_load;
	sums_t                      old_sum;
	sums_t                      new_sum;
	logic [bfd_pkg::RECIP_W-1:0] recip_m;
	logic [bfd_pkg::NCH-1:0][bfd_pkg::PROD_W-1:0] prod;

	// Stage advance: a stage moves when the next is free or moving; a non-last stage 2 word always moves.
	assign out_free = !out_valid_q || res.ready;
	assign s2_adv   = s2_valid_q && (!last_s2 || out_free);
	assign s2_free  = !s2_valid_q || s2_adv;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s1_free  = !s1_valid_q || s1_adv;
	assign pop      = q_valid && s1_free;
	assign out_load = s2_adv && last_s2;

	// Accumulate. A sum written at the same edge as our read is forwarded.
	always_comb begin
		old_sum = fwd_hit_s1 ? fwd_sum_s1 : rdata_s1;
		for (int c = 0; c < bfd_pkg::NCH; c++) begin
			if (rec_s1.first) begin
				new_sum[c] = bfd_pkg::SUM_W'(rec_s1.px[c]);
			end else begin
				new_sum[c] = old_sum[c] + bfd_pkg::SUM_W'(rec_s1.px[c]);
			end
		end
	end

	// Divide by the block area through a reciprocal multiply.
	always_comb begin
		recip_m = bfd_pkg::recip(factor_s2);
		for (int c = 0; c < bfd_pkg::NCH; c++) begin
			prod[c] = bfd_pkg::PROD_W'(sum_s2[c]) * bfd_pkg::PROD_W'(recip_m);
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= pop;
			end
			if (s2_free) begin
				s2_valid_q <= s1_adv;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Column sum memory and the payload of all stages.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			col_sum_mem[rec_s1.x] <= new_sum;
		end
		if (pop) begin
			rec_s1     <= q_rec;
			rdata_s1   <= col_sum_mem[q_rec.x];
			fwd_hit_s1 <= s1_adv && (rec_s1.x == q_rec.x);
			fwd_sum_s1 <= new_sum;
		end
		if (s1_adv) begin
			last_s2   <= rec_s1.last;
			done_s2   <= rec_s1.frame_done;
			x_s2      <= rec_s1.x;
			y_s2      <= rec_s1.y;
			factor_s2 <= rec_s1.factor;
			sum_s2    <= new_sum;
		end
		if (out_load) begin
			for (int c = 0; c < bfd_pkg::NCH; c++) begin
				out_px_q[c] <= prod[c][bfd_pkg::RECIP_SHIFT +: bfd_pkg::CH_W];
			end
			out_x_q    <= x_s2;
			out_y_q    <= y_s2;
			out_done_q <= done_s2;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_red    = out_px_q[2];
	assign res.out_green  = out_px_q[1];
	assign res.out_blue   = out_px_q[0];
	assign res.out_x      = out_x_q;
	assign res.out_y      = out_y_q;
	assign res.frame_done = out_done_q;

`ifndef NO_ASSERTIONS
	// A popped word always lands in stage 1.
	a_pop_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> s1_valid_q)
		else $error("popped word did not enter stage 1");

	// A stalled stage 1 word keeps its column address.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(rec_s1.x)))
		else $error("stage 1 word lost while stalled");

	// A finished block is never dropped while the output is busy.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && last_s2 && !out_free) |=> s2_valid_q)
		else $error("finished block dropped while output busy");
`endif

endmodule

// ===== sv/box_filter_downsampler.sv =====
// Box filter downscaler. Source RGB pixels come in raster order on pix, one
// word per pixel; each output word on res is the truncated per-channel mean
// of one factor-by-factor block, sent when the block's bottom-right pixel is
// taken, with its column and row in the reduced image and frame_done set on
// the frame's last block. Columns and rows past the last whole block are
// consumed and dropped. Registers on cfg: index 0 scale factor (1..8),
// index 1 source width, index 2 source height (1..1024); zero reads as one,
// larger values read as the maximum (scale takes only the low four data
// bits), and any write restarts the frame. Write them only while the block
// is idle. The block takes one pixel per clock while the queue is not full:
// the front end classifies pixels and feeds a four-word queue, and the back
// end does one read-modify-write per clock, unless the output holds it, on a
// column sum memory that is read at one address and written at the same or
// another in the same clock, with forwarding for back-to-back pixels of one
// block. Each result word passes stage 1, stage 2 and the output register.
module box_filter_downsampler (
	input  logic      clk,
	input  logic      arst_n,
	bfd_pix_if.sink   pix,
	bfd_res_if.source res,
	bfd_cfg_if.sink   cfg
);

	logic          push;
	logic          q_full;
	logic          q_valid;
	logic          pop;
	bfd_pkg::rec_t wr_rec;
	bfd_pkg::rec_t rd_rec;

	bfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.rec    (wr_rec)
	);

	bfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_rec  (wr_rec),
		.full    (q_full),
		.q_valid (q_valid),
		.pop     (pop),
		.rd_rec  (rd_rec)
	);

	bfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_rec   (rd_rec),
		.pop     (pop),
		.res     (res)
	);

endmodule
